### src/zstd_pkg.sv
package zstd_pkg;

  // Default sizing of the block.
  localparam int MaxElementsDef = 64;
  localparam int SampleBitsDef  = 16;

  // Result format: signed Q4.12 in a 16-bit word.
  localparam int OutBits  = 16;
  localparam int FracBits = 12;

  // The scale search finds one result bit per step, most significant first.
  localparam int YBits = OutBits;
  localparam int BitCntW = $clog2(YBits);

  // Left shift of the squared difference: 2 * FracBits for the Q4.12 scale,
  // plus 2 because the search compares (2c - 1)^2 instead of (c - 1/2)^2.
  localparam int LimShift = 2 * FracBits + 2;

  // Saturation bounds of the result.
  localparam logic [OutBits-1:0] OutMax = {1'b0, {(OutBits - 1){1'b1}}};
  localparam logic [OutBits-1:0] OutMin = {1'b1, {(OutBits - 1){1'b0}}};

  // Result side-band bits.
  localparam int TuserW = 2;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_STAT_MUL,
    OP_STAT_SUB,
    OP_READ,
    OP_MUL_X,
    OP_DIFF,
    OP_SQUARE,
    OP_INIT,
    OP_ADD,
    OP_CMP,
    OP_FINISH,
    OP_CLEAR
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic v_zero;
    logic overflow;
  } dp_status_t;

endpackage

### src/zstd_dp.sv
module zstd_dp #(
  parameter int MAX_ELEMENTS = zstd_pkg::MaxElementsDef,
  parameter int SAMPLE_BITS  = zstd_pkg::SampleBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  zstd_pkg::dp_cmd_t                 cmd_i,
  input  logic [$clog2(MAX_ELEMENTS)-1:0]   addr_i,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  output logic [$clog2(MAX_ELEMENTS+1)-1:0] count_o,
  output zstd_pkg::dp_status_t              status_o,
  output logic [zstd_pkg::OutBits-1:0]      normalized_o
);
  import zstd_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int SB = SAMPLE_BITS;
  localparam int SW = SB + CW;          // running sum, difference magnitude
  localparam int QW = 2 * SB + CW;      // running sum of squares
  localparam int VW = QW + CW;          // n*Q - S*S
  localparam int MW = 2 * SW;           // squared difference
  localparam int TW = VW + 2 * YBits + 4;  // search terms

  logic [CW-1:0] count_q;
  logic [SW-1:0] sum_q;
  logic [QW-1:0] sqs_q;
  logic          ovf_q;
  logic          full;

  logic [SB-1:0] mem [MAX_ELEMENTS];
  logic [SB-1:0] x_q;

  logic [VW-1:0] nq_q, ss_q, v_q;
  logic          vzero_q;
  logic [SW-1:0] nx_q, mag_q;
  logic          neg_q;
  logic [MW-1:0] m_q;
  logic signed [SW:0] diff;

  logic [TW-1:0]        p_q, v2_q, t_q, lim;
  logic signed [TW-1:0] r2_q, rv_q;
  logic                 fit;
  logic [YBits-1:0]     y_q;
  logic [OutBits-1:0]   norm_q, sat;

  assign full = (count_q == CW'(MAX_ELEMENTS));

  // Vector statistics: count, sum, sum of squares and the overflow flag; OP_CLEAR resets them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sqs_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.op == OP_LOAD) begin
      if (!full) begin
        count_q <= count_q + CW'(1);
        sum_q   <= sum_q + SW'(sample_i);
        sqs_q   <= sqs_q + QW'(sample_i) * QW'(sample_i);
      end else begin
        ovf_q <= 1'b1;
      end
    end else if (cmd_i.op == OP_CLEAR) begin
      count_q <= '0;
      sum_q   <= '0;
      sqs_q   <= '0;
      ovf_q   <= 1'b0;
    end
  end

  // Sample store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD && !full) begin
      mem[count_q[AW-1:0]] <= sample_i;
    end
    if (cmd_i.op == OP_READ) begin
      x_q <= mem[addr_i];
    end
  end

  assign diff = $signed({1'b0, nx_q}) - $signed({1'b0, sum_q});
  assign lim  = TW'({m_q, {LimShift{1'b0}}});
  assign fit  = (t_q <= lim);

  // Saturated, signed result of the search.
  always_comb begin
    if (neg_q) begin
      sat = (y_q > YBits'(32768)) ? OutMin : OutBits'(-y_q);
    end else begin
      sat = (y_q > YBits'(32767)) ? OutMax : OutBits'(y_q);
    end
  end

  // Variance, difference and the bit-by-bit scale search.
  // The search keeps P = a^2*v, R2 = a*v*2^(b+2) and V2 = v*2^(2b+2) with
  // a = 2y - 1, so every trial (a + 2^(b+1))^2 * v is P + R2 + V2.
  // An accepted bit makes the next R2 equal to (R2 + 2*V2) / 2.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_STAT_MUL: begin
        nq_q <= VW'(count_q) * VW'(sqs_q);
        ss_q <= VW'(sum_q) * VW'(sum_q);
      end
      OP_STAT_SUB: begin
        v_q     <= nq_q - ss_q;
        vzero_q <= (nq_q == ss_q);
      end
      OP_MUL_X: nx_q <= SW'(count_q) * SW'(x_q);
      OP_DIFF: begin
        neg_q <= diff[SW];
        mag_q <= diff[SW] ? SW'(-diff) : SW'(diff);
      end
      OP_SQUARE: m_q <= MW'(mag_q) * MW'(mag_q);
      OP_INIT: begin
        p_q  <= TW'(v_q);
        v2_q <= TW'(v_q) << (2 * YBits);
        r2_q <= -$signed(TW'(v_q) << (YBits + 1));
        y_q  <= '0;
      end
      OP_ADD: begin
        t_q  <= p_q + $unsigned(r2_q) + v2_q;
        rv_q <= r2_q + $signed(v2_q << 1);
      end
      OP_CMP: begin
        y_q  <= {y_q[YBits-2:0], fit};
        v2_q <= v2_q >> 2;
        if (fit) begin
          p_q  <= t_q;
          r2_q <= rv_q >>> 1;
        end else begin
          r2_q <= r2_q >>> 1;
        end
      end
      OP_FINISH: norm_q <= vzero_q ? '0 : sat;
      default: ;
    endcase
  end

  assign count_o         = count_q;
  assign status_o.v_zero   = vzero_q;
  assign status_o.overflow = ovf_q;
  assign normalized_o    = norm_q;

endmodule

### src/zstd_ctrl.sv
module zstd_ctrl #(
  parameter int MAX_ELEMENTS = zstd_pkg::MaxElementsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_valid_i,
  input  logic                              s_last_i,
  output logic                              s_ready_o,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic                              m_last_o,
  input  logic [$clog2(MAX_ELEMENTS+1)-1:0] count_i,
  output zstd_pkg::dp_cmd_t                 cmd_o,
  output logic [$clog2(MAX_ELEMENTS)-1:0]   addr_o
);
  import zstd_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [3:0] {
    S_LOAD,
    S_STAT_MUL,
    S_STAT_SUB,
    S_READ,
    S_MUL_X,
    S_DIFF,
    S_SQUARE,
    S_INIT,
    S_ADD,
    S_CMP,
    S_FINISH,
    S_EMIT
  } state_e;

  state_e             state_q;
  logic [AW-1:0]      idx_q;
  logic [BitCntW-1:0] bit_q;
  logic               final_item;

  assign final_item = (CW'(idx_q) == count_i - CW'(1));

  // Sequencer: load, statistics, then one search per stored sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      idx_q   <= '0;
      bit_q   <= '0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (s_valid_i && s_last_i) begin
            state_q <= S_STAT_MUL;
            idx_q   <= '0;
          end
        end
        S_STAT_MUL: state_q <= S_STAT_SUB;
        S_STAT_SUB: state_q <= S_READ;
        S_READ:     state_q <= S_MUL_X;
        S_MUL_X:    state_q <= S_DIFF;
        S_DIFF:     state_q <= S_SQUARE;
        S_SQUARE:   state_q <= S_INIT;
        S_INIT: begin
          state_q <= S_ADD;
          bit_q   <= BitCntW'(YBits - 1);
        end
        S_ADD: state_q <= S_CMP;
        S_CMP: begin
          if (bit_q == '0) begin
            state_q <= S_FINISH;
          end else begin
            bit_q   <= bit_q - BitCntW'(1);
            state_q <= S_ADD;
          end
        end
        S_FINISH: state_q <= S_EMIT;
        S_EMIT: begin
          if (m_ready_i) begin
            if (final_item) begin
              state_q <= S_LOAD;
            end else begin
              idx_q   <= idx_q + AW'(1);
              state_q <= S_READ;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  // Datapath command for the current state.
  always_comb begin
    unique case (state_q)
      S_LOAD:     cmd_o.op = s_valid_i ? OP_LOAD : OP_NONE;
      S_STAT_MUL: cmd_o.op = OP_STAT_MUL;
      S_STAT_SUB: cmd_o.op = OP_STAT_SUB;
      S_READ:     cmd_o.op = OP_READ;
      S_MUL_X:    cmd_o.op = OP_MUL_X;
      S_DIFF:     cmd_o.op = OP_DIFF;
      S_SQUARE:   cmd_o.op = OP_SQUARE;
      S_INIT:     cmd_o.op = OP_INIT;
      S_ADD:      cmd_o.op = OP_ADD;
      S_CMP:      cmd_o.op = OP_CMP;
      S_FINISH:   cmd_o.op = OP_FINISH;
      S_EMIT:     cmd_o.op = (m_ready_i && final_item) ? OP_CLEAR : OP_NONE;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  assign addr_o    = idx_q;
  assign s_ready_o = (state_q == S_LOAD);
  assign m_valid_o = (state_q == S_EMIT);
  assign m_last_o  = final_item;

  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_ready_o && m_valid_o))
    else $error("input and output sides open at once");

  // A result only names a stored sample.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o |-> (CW'(idx_q) < count_i))
    else $error("result index beyond stored samples");

  // The final result transfer reopens loading.
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && m_ready_i && m_last_o) |=> s_ready_o)
    else $error("loading not reopened after final result");

  // A last sample closes loading.
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o && s_last_i) |=> !s_ready_o)
    else $error("loading still open after last sample");

endmodule

### src/zscore_standardizer_top.sv
// Z-score standardizer. Samples stream in one per cycle and are stored
// along with their exact running sum and sum of squares; the transfer
// marked tlast starts the output phase, during which no input is taken.
// For every stored sample, in arrival order, the block emits
// round(4096 * (n*x - S) / sqrt(n*Q - S*S)) as signed Q4.12, saturated,
// with tlast on the final result. Statistics are computed in a multiply
// step and a subtract step; each result then goes through store read,
// difference, squaring, search setup, a 16-step search that finds one
// result bit per step with a wide add and a compare, and output, and is
// held until the downstream transfer before the next sample starts. A
// zero deviation gives zero results with tuser bit 0 set; samples
// beyond MAX_ELEMENTS are dropped and tuser bit 1 is set on that
// vector's results.
module zscore_standardizer_top #(
  parameter int MAX_ELEMENTS = zstd_pkg::MaxElementsDef,
  parameter int SAMPLE_BITS  = zstd_pkg::SampleBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: sample (SAMPLE_BITS, low bits), zero padding to whole bytes
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // tdata: normalized (16, signed Q4.12)
  output logic [zstd_pkg::OutBits-1:0]          m_axis_tdata,
  output logic                                  m_axis_tlast,
  // tuser: zero_spread (bit 0), overflowed (bit 1)
  output logic [zstd_pkg::TuserW-1:0]           m_axis_tuser
);
  import zstd_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  dp_cmd_t       cmd;
  dp_status_t    status;
  logic [AW-1:0] addr;
  logic [CW-1:0] count;

  zstd_ctrl #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_last_o  (m_axis_tlast),
    .count_i   (count),
    .cmd_o     (cmd),
    .addr_o    (addr)
  );

  zstd_dp #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .addr_i       (addr),
    .sample_i     (s_axis_tdata[SAMPLE_BITS-1:0]),
    .count_o      (count),
    .status_o     (status),
    .normalized_o (m_axis_tdata)
  );

  assign m_axis_tuser = {status.overflow, status.v_zero};

endmodule
